@@ hdl/sslc_pkg.sv @@
package sslc_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int SEED_W     = 64;
    localparam int LEN_W      = 7;
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LENGTH);

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SEED_LEN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_READ_LEN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SEED_LONGER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_MISMATCH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_COUNT = 1'd1;

    typedef struct packed {
        logic done;
        logic pass;
    } t_scan_res;

endpackage

@@ hdl/spaced_seed_lossless_check_top.sv @@
// An item with a parameter error goes from idle straight to the done state and is then
// registered onto the output. A valid item first steps through every seed position to find its
// first and last care positions, then searches mismatch sets depth first; each candidate is
// scanned row by row in the shared scan unit; each backtrack reads the pick stack in S_POP.
// Throughput: one item at a time; a new item is taken once the search has finished.
// Reset (synchronous, active low) returns to idle, drops the output and sets
// read_length to 64 and mismatch_count to 1.
module spaced_seed_lossless_check_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sslc_pkg::SEED_W-1:0]    i_seed_pattern,
    input  logic [sslc_pkg::LEN_W-1:0]     i_seed_length,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sslc_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_usable,
    output logic [sslc_pkg::SEED_W-1:0]    o_failing_positions,
    input  logic                           i_cfg_we,
    input  logic [sslc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sslc_pkg::LEN_W-1:0]     i_cfg_data
);
    import sslc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_TRY  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [LEN_W-1:0]    r_read_length;
    logic [LEN_W-1:0]    r_mismatch_count;

    logic [SEED_W-1:0]   r_seed;
    logic [LEN_W-1:0]    r_len_s;
    logic [SEED_W-1:0]   r_pscan;
    logic [POS_W-1:0]    r_k;
    logic                r_any;
    logic [LEN_W-1:0]    r_first;
    logic [LEN_W-1:0]    r_last;
    logic [LEN_W-1:0]    r_rows;

    logic [SEED_W-1:0]   r_set;
    logic [POS_W-1:0]    r_d;
    logic [LEN_W-1:0]    r_p;
    logic [LEN_W-1:0]    r_next;
    logic [LEN_W-1:0]    r_rem;

    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_usable;
    logic [SEED_W-1:0]   r_res_mask;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic                r_usable;
    logic [SEED_W-1:0]   r_mask;

    logic                w_in_xfer;
    logic [STATUS_W-1:0] w_status;
    logic [SEED_W-1:0]   w_len_mask;
    logic                w_room;
    logic [SEED_W-1:0]   w_pbit;
    logic [SEED_W-1:0]   w_popbit;
    logic                w_prep_any;
    logic                w_push;
    logic                w_scan_start;
    logic [POS_W-1:0]    w_rdata;
    t_scan_res           w_scan;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_len_mask = ~({SEED_W{1'b1}} << i_seed_length);

    always_comb begin
        priority if ((i_seed_length == '0) || (i_seed_length > MAX_LEN_V)) begin
            w_status = ST_BAD_SEED_LEN;
        end else if ((r_read_length < LEN_W'(2)) || (r_read_length > MAX_LEN_V)) begin
            w_status = ST_BAD_READ_LEN;
        end else if (i_seed_length > r_read_length) begin
            w_status = ST_SEED_LONGER;
        end else if ((r_mismatch_count == '0) || (r_mismatch_count > r_read_length)) begin
            w_status = ST_BAD_MISMATCH;
        end else begin
            w_status = ST_OK;
        end
    end

    // A candidate is tried only while enough positions remain for the rest of the set.
    assign w_room       = (r_read_length - r_p) >= (r_mismatch_count - {1'b0, r_d});
    assign w_pbit       = SEED_W'(1) << r_p[POS_W-1:0];
    assign w_popbit     = SEED_W'(1) << w_rdata;
    assign w_prep_any   = r_any || r_pscan[0];
    assign w_scan_start = (r_state == S_TRY) && w_room;
    assign w_push       = (r_state == S_SCAN) && w_scan.done && w_scan.pass && (r_rem != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (w_status == ST_OK) ? S_PREP : S_DONE;
                end
            end
            S_PREP: begin
                if (r_k == '1) begin
                    n_state = w_prep_any ? S_TRY : S_DONE;
                end
            end
            S_TRY: begin
                if (w_room) begin
                    n_state = S_SCAN;
                end else if (r_d == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_SCAN: begin
                if (w_scan.done) begin
                    n_state = (w_scan.pass && (r_rem == '0)) ? S_DONE : S_TRY;
                end
            end
            S_POP: begin
                n_state = S_TRY;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_read_length    <= LEN_W'(64);
            r_mismatch_count <= LEN_W'(1);
            r_ovalid         <= 1'b0;
            r_d              <= '0;
            r_p              <= '0;
            r_k              <= '0;
            r_any            <= 1'b0;
            r_set            <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_READ_LENGTH:    r_read_length    <= i_cfg_data;
                    CFG_MISMATCH_COUNT: r_mismatch_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_seed       <= i_seed_pattern & w_len_mask;
                        r_pscan      <= i_seed_pattern & w_len_mask;
                        r_len_s      <= i_seed_length;
                        r_k          <= '0;
                        r_any        <= 1'b0;
                        r_first      <= '0;
                        r_last       <= '0;
                        r_res_status <= w_status;
                        r_res_usable <= 1'b0;
                        r_res_mask   <= '0;
                    end
                end
                S_PREP: begin
                    if (r_pscan[0]) begin
                        if (!r_any) begin
                            r_first <= {1'b0, r_k};
                        end
                        r_last <= {1'b0, r_k};
                        r_any  <= 1'b1;
                    end
                    r_pscan <= r_pscan >> 1;
                    r_k     <= r_k + 1'b1;
                    if (r_k == '1) begin
                        r_set        <= '0;
                        r_d          <= '0;
                        r_p          <= '0;
                        r_rows       <= r_read_length - r_len_s + 1'b1;
                        // A seed without care positions is avoided by every row.
                        r_res_usable <= !w_prep_any;
                    end
                end
                S_TRY: begin
                    if (w_room) begin
                        r_set  <= r_set | w_pbit;
                        r_next <= r_p + 1'b1;
                        r_rem  <= r_mismatch_count - {1'b0, r_d} - 1'b1;
                    end else if (r_d == '0) begin
                        r_res_usable <= 1'b1;
                    end else begin
                        r_d <= r_d - 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_scan.done) begin
                        if (w_scan.pass && (r_rem == '0)) begin
                            r_res_mask <= r_set;
                        end else if (w_scan.pass) begin
                            r_d <= r_d + 1'b1;
                            r_p <= r_p + 1'b1;
                        end else begin
                            r_set <= r_set & ~w_pbit;
                            r_p   <= r_p + 1'b1;
                        end
                    end
                end
                S_POP: begin
                    r_set <= r_set & ~w_popbit;
                    r_p   <= {1'b0, w_rdata} + 1'b1;
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase

            if ((r_state == S_DONE) && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
                r_status <= r_res_status;
                r_usable <= r_res_usable;
                r_mask   <= r_res_mask;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    sslc_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_LENGTH)
    ) u_pick_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_d),
        .i_wdata (r_p[POS_W-1:0]),
        .i_raddr (r_d - 1'b1),
        .o_rdata (w_rdata)
    );

    sslc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_start),
        .i_win   (r_set | w_pbit),
        .i_seed  (r_seed),
        .i_first (r_first),
        .i_last  (r_last),
        .i_next  (r_next),
        .i_rem   (r_rem),
        .i_rows  (r_rows),
        .o_res   (w_scan)
    );

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_ovalid;
    assign o_status            = r_status;
    assign o_usable            = r_usable;
    assign o_failing_positions = r_mask;

endmodule

@@ hdl/sslc_ram.sv @@
module sslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sslc_scan.sv @@
module sslc_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sslc_pkg::SEED_W-1:0] i_win,
    input  logic [sslc_pkg::SEED_W-1:0] i_seed,
    input  logic [sslc_pkg::LEN_W-1:0]  i_first,
    input  logic [sslc_pkg::LEN_W-1:0]  i_last,
    input  logic [sslc_pkg::LEN_W-1:0]  i_next,
    input  logic [sslc_pkg::LEN_W-1:0]  i_rem,
    input  logic [sslc_pkg::LEN_W-1:0]  i_rows,
    output sslc_pkg::t_scan_res         o_res
);
    import sslc_pkg::*;

    logic              r_act;
    logic [SEED_W-1:0] r_win;
    logic [LEN_W-1:0]  r_n;
    logic [LEN_W-1:0]  r_need;
    logic [LEN_W:0]    r_end;
    logic              r_have;
    logic              r_done;
    logic              r_pass;

    logic              w_unhit;
    logic [LEN_W:0]    w_lo;
    logic [LEN_W:0]    w_hi;
    logic [LEN_W:0]    w_next;
    logic [LEN_W:0]    w_start;
    logic              w_late;
    logic              w_newint;
    logic [LEN_W-1:0]  w_need;
    logic              w_over;
    logic              w_last_row;

    // One row per cycle: the window holds the chosen set shifted down to the row offset.
    always_comb begin
        w_unhit    = ~|(r_win & i_seed);
        w_lo       = {1'b0, r_n} + {1'b0, i_first};
        w_hi       = {1'b0, r_n} + {1'b0, i_last};
        w_next     = {1'b0, i_next};
        w_start    = (w_lo > w_next) ? w_lo : w_next;
        w_late     = w_unhit && (w_hi < w_next);
        // Rows whose care spans do not overlap each need a position of their own.
        w_newint   = w_unhit && (!r_have || (w_start > r_end));
        w_need     = r_need + LEN_W'(w_newint);
        w_over     = w_need > i_rem;
        w_last_row = (r_n == (i_rows - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_pass <= 1'b0;
            r_have <= 1'b0;
            r_n    <= '0;
            r_need <= '0;
            r_end  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act  <= 1'b1;
                r_win  <= i_win;
                r_n    <= '0;
                r_need <= '0;
                r_end  <= '0;
                r_have <= 1'b0;
            end else if (r_act) begin
                if (w_late || w_over) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                    r_pass <= 1'b0;
                end else if (w_last_row) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                    r_pass <= 1'b1;
                end else begin
                    r_win  <= r_win >> 1;
                    r_n    <= r_n + 1'b1;
                    r_need <= w_need;
                    if (w_newint) begin
                        r_have <= 1'b1;
                        r_end  <= w_hi;
                    end
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.pass = r_pass;

endmodule

@@ hdl/sslc_check.sv @@
module sslc_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [sslc_pkg::STATUS_W-1:0]  o_status,
    input logic                           o_usable,
    input logic [sslc_pkg::SEED_W-1:0]    o_failing_positions
);
    import sslc_pkg::*;

    // A stalled result keeps its value until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_usable)
             && $stable(o_failing_positions)))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    // A parameter error carries no verdict and no mask.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (!o_usable && (o_failing_positions == '0)))
        else $error("error result with verdict or mask");

    // A usable seed reports no mask; an unusable one names a nonempty set.
    a_mask_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |->
            (o_usable == (o_failing_positions == '0)))
        else $error("mask disagrees with verdict");

endmodule

bind spaced_seed_lossless_check_top sslc_check u_sslc_check (.*);

@@ test/spaced_seed_lossless_check_top_test.sv @@
`timescale 1ns / 1ps

module spaced_seed_lossless_check_top_test;
    import sslc_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                usable;
        logic [SEED_W-1:0]   mask;
    } t_verdict;

    // Holds the register copy, predicts one verdict per accepted seed and checks
    // the verdicts coming out of the block in order.
    class seed_verdict_board;
        logic [LEN_W-1:0] read_len;
        logic [LEN_W-1:0] mm_count;
        t_verdict         verdicts[$];
        int errors;
        int checks;
        int usable_seen;
        int failing_seen;
        int param_errors;
        int reg_writes;

        logic [SEED_W-1:0] pat;
        int len_s;
        int len_r;
        int rows;
        int need;
        int first_c;
        int last_c;
        int hits[MAX_LENGTH];
        int pick[MAX_LENGTH];

        function new();
            read_len = LEN_W'(64);
            mm_count = LEN_W'(1);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            if (idx == CFG_READ_LENGTH) begin
                read_len = val;
            end else begin
                mm_count = val;
            end
            reg_writes++;
        endfunction

        function int care(int k);
            if (k >= len_s || k >= SEED_W) begin
                return 0;
            end
            return int'(pat[k]);
        endfunction

        // Adds delta to the hit count of every seed placement that cares at read position p.
        function void tally(int p, int delta);
            int lo;
            int hi;
            int n;
            lo = (p + 1 > len_s) ? p + 1 - len_s : 0;
            hi = (p < rows - 1) ? p : rows - 1;
            for (n = lo; n <= hi; n++) begin
                if (care(p - n) != 0) begin
                    hits[n] += delta;
                end
            end
        endfunction

        // Lower bound on the positions still needed to hit every unhit placement:
        // placements whose care spans do not overlap need a position each.
        function bit coverable(int next, int r);
            int need_rows;
            int end_sel;
            int start;
            int n;
            bit have;
            if (len_r - next < r) begin
                return 0;
            end
            need_rows = 0;
            end_sel = 0;
            have = 0;
            for (n = 0; n < rows; n++) begin
                if (hits[n] == 0) begin
                    if (n + last_c < next) begin
                        return 0;
                    end
                    start = (n + first_c > next) ? n + first_c : next;
                    if (!have || start > end_sel) begin
                        need_rows++;
                        end_sel = n + last_c;
                        have = 1;
                    end
                end
            end
            return need_rows <= r;
        endfunction

        // Depth-first walk over sorted position sets; stops at the first set that
        // hits every placement, which is then left in pick.
        function bit first_uncovered();
            int depth;
            int p;
            bit found;
            bit done;
            depth = 0;
            p = 0;
            found = 0;
            done = 0;
            while (!done) begin
                if (depth == need) begin
                    found = 1;
                    done = 1;
                end else if (p >= len_r || len_r - p < need - depth) begin
                    if (depth == 0) begin
                        done = 1;
                    end else begin
                        depth--;
                        p = pick[depth];
                        tally(p, -1);
                        p++;
                    end
                end else begin
                    tally(p, 1);
                    pick[depth] = p;
                    if (coverable(p + 1, need - depth - 1)) begin
                        depth++;
                    end else begin
                        tally(p, -1);
                    end
                    p++;
                end
            end
            return found;
        endfunction

        function void note_seed(logic [SEED_W-1:0] pattern, logic [LEN_W-1:0] slen);
            t_verdict v;
            int k;
            bit any;
            pat = pattern;
            len_s = int'(slen);
            len_r = int'(read_len);
            need = int'(mm_count);
            v = '0;
            v.status = ST_OK;
            if (len_s < 1 || len_s > MAX_LENGTH) begin
                v.status = ST_BAD_SEED_LEN;
            end else if (len_r < 2 || len_r > MAX_LENGTH) begin
                v.status = ST_BAD_READ_LEN;
            end else if (len_s > len_r) begin
                v.status = ST_SEED_LONGER;
            end else if (need < 1 || need > len_r) begin
                v.status = ST_BAD_MISMATCH;
            end
            if (v.status == ST_OK) begin
                rows = len_r - len_s + 1;
                first_c = 0;
                last_c = 0;
                any = 0;
                for (k = 0; k < len_s; k++) begin
                    if (care(k) != 0) begin
                        if (!any) begin
                            first_c = k;
                        end
                        last_c = k;
                        any = 1;
                    end
                end
                for (k = 0; k < MAX_LENGTH; k++) begin
                    hits[k] = 0;
                end
                if (!any || !first_uncovered()) begin
                    v.usable = 1'b1;
                end else begin
                    for (k = 0; k < need; k++) begin
                        v.mask[pick[k]] = 1'b1;
                    end
                end
            end
            verdicts.push_back(v);
        endfunction

        task report(string field, logic [SEED_W-1:0] got, logic [SEED_W-1:0] want);
            $display("%0t: mismatch in %s: got %h, expected %h", $time, field, got, want);
            errors++;
        endtask

        task check_verdict(logic [STATUS_W-1:0] st, logic us, logic [SEED_W-1:0] mask);
            t_verdict v;
            if (verdicts.size() == 0) begin
                report("unexpected transfer, status", SEED_W'(st), '0);
            end else begin
                v = verdicts.pop_front();
                checks++;
                if (v.status != ST_OK) begin
                    param_errors++;
                end else if (v.usable) begin
                    usable_seen++;
                end else begin
                    failing_seen++;
                end
                if (st !== v.status) begin
                    report("status", SEED_W'(st), SEED_W'(v.status));
                end
                if (us !== v.usable) begin
                    report("usable", SEED_W'(us), SEED_W'(v.usable));
                end
                if (mask !== v.mask) begin
                    report("failing_positions", mask, v.mask);
                end
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [SEED_W-1:0]    i_seed_pattern = '0;
    logic [LEN_W-1:0]     i_seed_length = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_usable;
    logic [SEED_W-1:0]    o_failing_positions;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    int send_idle = 24;
    int recv_idle = 59;

    seed_verdict_board board = new();

    spaced_seed_lossless_check_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_seed_pattern     (i_seed_pattern),
        .i_seed_length      (i_seed_length),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_usable           (o_usable),
        .o_failing_positions(o_failing_positions),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic send(logic [SEED_W-1:0] pattern, logic [LEN_W-1:0] slen);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_seed_pattern <= pattern;
        i_seed_length  <= slen;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.note_seed(pattern, slen);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.verdicts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers only change once every verdict of the previous setting is back.
    task automatic set_regs(logic [LEN_W-1:0] r, logic [LEN_W-1:0] m);
        drain();
        write_reg(CFG_READ_LENGTH, r);
        write_reg(CFG_MISMATCH_COUNT, m);
    endtask

    initial begin
        @(posedge i_rst_n);
        forever begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                board.check_verdict(o_status, o_usable, o_failing_positions);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [LEN_W-1:0]  r;
        logic [LEN_W-1:0]  m;
        logic [LEN_W-1:0]  slen;
        logic [SEED_W-1:0] pat;
        int sel;
        int hi;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: length limits, check order, ignored high pattern bits and
        // the largest mismatch sets.
        set_regs(7'd64, 7'd1);
        send('0, 7'd0);
        send('1, 7'd127);
        send(64'd1, 7'd65);
        send('1, 7'd64);
        send(64'd1, 7'd1);
        send('0, 7'd64);
        send(64'h8000_0000_0000_0000, 7'd64);
        send(~64'hF, 7'd4);
        set_regs(7'd64, 7'd64);
        send('1, 7'd64);
        send(64'd1, 7'd1);
        set_regs(7'd64, 7'd65);
        send(64'd5, 7'd3);
        set_regs(7'd64, 7'd0);
        send('1, 7'd64);
        set_regs(7'd1, 7'd1);
        send(64'd1, 7'd1);
        send(64'd1, 7'd0);
        set_regs(7'd0, 7'd1);
        send(64'd1, 7'd1);
        set_regs(7'd127, 7'd5);
        send(64'd1, 7'd1);
        set_regs(7'd5, 7'd2);
        send('1, 7'd6);
        send(64'd17, 7'd5);
        send(64'd1, 7'd2);
        set_regs(7'd2, 7'd2);
        send(64'd3, 7'd2);
        set_regs(7'd64, 7'd2);
        send('1, 7'd64);

        // Random: short reads keep the set search cheap; full-length reads only
        // with one mismatch or with every position mismatched.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 24 : (mode == 1) ? 59 : 0;
            recv_idle = (mode == 0) ? 59 : (mode == 1) ? 24 : 0;
            for (int s = 0; s < 4; s++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    r = LEN_W'($urandom_range(0, 1));
                end else if (sel == 1) begin
                    r = LEN_W'($urandom_range(65, 127));
                end else if (sel == 2) begin
                    r = 7'd64;
                end else begin
                    r = LEN_W'($urandom_range(2, 12));
                end
                if (r == 7'd64) begin
                    m = ($urandom_range(0, 1) != 0) ? 7'd1 : 7'd64;
                end else if (r < 2 || r > 64) begin
                    m = LEN_W'($urandom_range(0, 127));
                end else begin
                    sel = $urandom_range(0, 9);
                    hi = (r < 3) ? int'(r) : 3;
                    if (sel == 0) begin
                        m = 7'd0;
                    end else if (sel == 1) begin
                        m = LEN_W'($urandom_range(int'(r) + 1, 127));
                    end else if (sel == 2) begin
                        m = r;
                    end else begin
                        m = LEN_W'($urandom_range(1, hi));
                    end
                end
                set_regs(r, m);
                repeat (8) begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0) begin
                        slen = 7'd0;
                    end else if (sel == 1) begin
                        slen = LEN_W'($urandom_range(65, 127));
                    end else if (sel == 2 && r >= 2 && r < 64) begin
                        slen = LEN_W'($urandom_range(int'(r) + 1, 64));
                    end else begin
                        hi = (r >= 2 && r <= 64) ? int'(r) : 64;
                        slen = LEN_W'($urandom_range(1, hi));
                    end
                    pat = {$urandom(), $urandom()};
                    sel = $urandom_range(0, 3);
                    if (sel == 1) begin
                        pat &= {$urandom(), $urandom()};
                    end else if (sel == 2) begin
                        pat &= {$urandom(), $urandom()} & {$urandom(), $urandom()};
                    end else if (sel == 3) begin
                        pat = ($urandom_range(0, 1) != 0) ? (64'd1 << $urandom_range(0, 63))
                                                          : '0;
                    end
                    send(pat, slen);
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("checked %0d seeds over %0d register writes", board.checks, board.reg_writes);
        $display("%0d usable, %0d with a failing set, %0d parameter errors",
                 board.usable_seen, board.failing_seen, board.param_errors);
        if (board.errors == 0 && board.verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ spaced_seed_lossless_check_top.f @@
hdl/sslc_pkg.sv
hdl/sslc_ram.sv
hdl/sslc_scan.sv
hdl/spaced_seed_lossless_check_top.sv
hdl/sslc_check.sv
test/spaced_seed_lossless_check_top_test.sv
